>>> hw/rtl/mbb_pkg.sv
// Shared constants and codes for the page-organized monochrome blitter.
package mbb_pkg;

  // Default sizes of the frame and source stores
  localparam int MAX_FRAME_WIDTH_DEF = 128;
  localparam int MAX_FRAME_PAGES_DEF = 8;
  localparam int SOURCE_BYTES_DEF    = 2048;

  // Signed width that covers every clipping sum
  localparam int CLIP_W = 12;

  // Command codes
  localparam logic [2:0] CMD_WRITE_SRC = 3'd0;
  localparam logic [2:0] CMD_BLIT      = 3'd1;
  localparam logic [2:0] CMD_PIXEL     = 3'd2;
  localparam logic [2:0] CMD_HLINE     = 3'd3;
  localparam logic [2:0] CMD_CLEAR     = 3'd4;
  localparam logic [2:0] CMD_READ      = 3'd5;

  // Configuration register indexes
  localparam logic [1:0] REG_FRAME_WIDTH  = 2'd0;
  localparam logic [1:0] REG_FRAME_HEIGHT = 2'd1;
  localparam logic [1:0] REG_SRC_STRIDE   = 2'd2;

  // Result of clipping one axis
  typedef struct packed {
    logic [CLIP_W-1:0] cnt;
    logic [9:0]        src;
    logic [7:0]        dst;
  } clip_t;

endpackage

>>> hw/rtl/mbb_ram.sv
// Generic simple dual-port RAM with registered read.
module mbb_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port and registered read port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

>>> hw/rtl/mono_bitmap_blit_page_frame_top.sv
// Top level of the page-organized monochrome blitter with frame and source memories.
//
// A command is taken when start is high and busy is low; its single result (read_data,
// drawn) appears on the result ports for exactly one cycle marked by done, and the
// receiver cannot stall it. Source writes, undefined codes, reads outside the frame
// store and drawing commands that clip away entirely answer in the cycle after the
// transfer; a frame read passes through the read state and then answers. Blit, pixel
// and horizontal line take each visible pixel through address calculation, memory
// read, and modify and write back on the frame memory, and answer after the last
// write back. Clear sweeps all MAX_FRAME_WIDTH*MAX_FRAME_PAGES bytes of the frame
// memory (1024 by default) one byte a cycle, and answers in the cycle after the sweep;
// the same sweep runs after reset, with busy high, before the first command is taken.
// Configuration writes are taken in any cycle.
module mono_bitmap_blit_page_frame_top
  import mbb_pkg::*;
#(
  parameter int MAX_FRAME_WIDTH = MAX_FRAME_WIDTH_DEF,
  parameter int MAX_FRAME_PAGES = MAX_FRAME_PAGES_DEF,
  parameter int SOURCE_BYTES    = SOURCE_BYTES_DEF
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              cfg_we,
  input  logic [1:0]        cfg_index,
  input  logic [7:0]        cfg_data,
  input  logic              start,
  output logic              busy,
  input  logic [2:0]        cmd,
  input  logic signed [8:0] dest_x,
  input  logic signed [8:0] dest_y,
  input  logic [7:0]        source_x,
  input  logic [7:0]        source_y,
  input  logic [7:0]        span_width,
  input  logic [7:0]        span_height,
  input  logic              pixel_on,
  input  logic [10:0]       mem_addr,
  input  logic [7:0]        mem_data,
  output logic              done,
  output logic [7:0]        read_data,
  output logic              drawn
);

  localparam int FRAME_BYTES = MAX_FRAME_WIDTH * MAX_FRAME_PAGES;
  localparam int FAW = $clog2(FRAME_BYTES);
  localparam int SBW = $clog2(SOURCE_BYTES);
  localparam int XW  = $clog2(MAX_FRAME_WIDTH + 1);
  localparam int YW  = $clog2(MAX_FRAME_PAGES * 8 + 1);
  localparam int PGW = YW - 3;
  localparam int PW  = PGW + XW + 1;
  localparam int SAW = 18;
  localparam int MAW = 17;

  localparam logic [2:0] ST_IDLE  = 3'd0;
  localparam logic [2:0] ST_CLEAR = 3'd1;
  localparam logic [2:0] ST_CALC  = 3'd2;
  localparam logic [2:0] ST_READ  = 3'd3;
  localparam logic [2:0] ST_WRITE = 3'd4;
  localparam logic [2:0] ST_RDF   = 3'd5;

  // Configuration registers
  logic [7:0] frame_width;
  logic [6:0] frame_height;
  logic [5:0] source_stride_bytes;

  always_ff @(posedge clk) begin
    if (rst) begin
      frame_width         <= 8'd128;
      frame_height        <= 7'd64;
      source_stride_bytes <= 6'd16;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_FRAME_WIDTH:  frame_width         <= cfg_data;
        REG_FRAME_HEIGHT: frame_height        <= cfg_data[6:0];
        REG_SRC_STRIDE:   source_stride_bytes <= cfg_data[5:0];
        default: ;
      endcase
    end
  end

  // Saturate the frame size at the store limits
  logic [XW-1:0] fw;
  logic [YW-1:0] fh;
  assign fw = ({2'b00, frame_width} > 10'(MAX_FRAME_WIDTH)) ? XW'(MAX_FRAME_WIDTH)
                                                            : XW'(frame_width);
  assign fh = ({2'b00, frame_height} > 9'(MAX_FRAME_PAGES * 8)) ? YW'(MAX_FRAME_PAGES * 8)
                                                                : YW'(frame_height);

  // Clip one axis against [0, lim)
  function automatic clip_t clip_axis(logic signed [8:0] dst, logic [7:0] src,
                                      logic [7:0] len, logic signed [CLIP_W-1:0] lim);
    clip_t r;
    logic signed [CLIP_W-1:0] d;
    logic signed [CLIP_W-1:0] e;
    logic signed [CLIP_W-1:0] dn;
    logic signed [CLIP_W-1:0] m;
    d     = {{(CLIP_W-9){dst[8]}}, dst};
    e     = d + $signed({{(CLIP_W-8){1'b0}}, len});
    dn    = d;
    r.src = {2'b00, src};
    r.cnt = '0;
    if (d < 0) begin
      r.src = {2'b00, src} + 10'(-d);
      dn    = '0;
    end
    m = (e > lim) ? lim : e;
    if (dn < lim && e > dn) begin
      r.cnt = m - dn;
    end
    r.dst = dn[7:0];
    return r;
  endfunction

  // Setup: decode the drawing command and clip it to the visible frame
  logic       is_blit;
  logic       is_pix;
  logic       is_draw;
  logic [7:0] xlen;
  logic [7:0] ylen;
  clip_t      cx;
  clip_t      cy;
  logic       hit;

  assign is_blit = (cmd == CMD_BLIT);
  assign is_pix  = (cmd == CMD_PIXEL);
  assign is_draw = cmd inside {CMD_BLIT, CMD_PIXEL, CMD_HLINE};
  assign xlen    = is_pix ? 8'd1 : span_width;
  assign ylen    = is_blit ? span_height : 8'd1;
  assign cx      = clip_axis(dest_x, source_x, xlen,
                             $signed({{(CLIP_W-XW){1'b0}}, fw}));
  assign cy      = clip_axis(dest_y, source_y, ylen,
                             $signed({{(CLIP_W-YW){1'b0}}, fh}));
  assign hit     = (cx.cnt != '0) && (cy.cnt != '0);

  // Control and walk registers
  logic [2:0]     state;
  logic [FAW-1:0] clr_cnt;
  logic           clr_reply;
  logic [XW-1:0]  cw;
  logic [YW-1:0]  ch;
  logic [XW-1:0]  i_cnt;
  logic [YW-1:0]  j_cnt;
  logic [7:0]     cdx;
  logic [7:0]     cdy;
  logic [9:0]     csx;
  logic [9:0]     csy;
  logic           mode_blit;
  logic           draw_val;
  logic [FAW-1:0] fidx;
  logic [2:0]     fbit;
  logic [SAW-1:0] saddr;
  logic [2:0]     sbit_sel;
  logic           done_next;

  // Address calculation for the current pixel
  logic [YW-1:0]  cur_y;
  logic [XW-1:0]  cur_x;
  logic [PGW-1:0] page;
  logic [PW-1:0]  fidx_c;
  logic [10:0]    scol;
  logic [10:0]    srow;
  logic [SAW-1:0] saddr_c;

  assign cur_y   = YW'({1'b0, cdy} + 9'(j_cnt));
  assign cur_x   = XW'({3'b000, cdx} + 11'(i_cnt));
  assign page    = cur_y[YW-1:3];
  assign fidx_c  = PW'(page) * PW'(fw) + PW'(cur_x);
  assign scol    = {1'b0, csx} + 11'(i_cnt);
  assign srow    = {1'b0, csy} + 11'(j_cnt);
  assign saddr_c = SAW'(srow) * SAW'(source_stride_bytes) + SAW'(scol[10:3]);

  // Memories
  logic           fr_we;
  logic [FAW-1:0] fr_waddr;
  logic [7:0]     fr_wdata;
  logic [FAW-1:0] fr_raddr;
  logic [7:0]     fr_q;
  logic           src_we;
  logic [SBW-1:0] src_raddr;
  logic [7:0]     src_q;
  logic [MAW-1:0] maddr;

  assign maddr = MAW'(mem_addr);

  mbb_ram #(.WIDTH(8), .DEPTH(FRAME_BYTES)) u_frame (
    .clk   (clk),
    .we    (fr_we),
    .waddr (fr_waddr),
    .wdata (fr_wdata),
    .raddr (fr_raddr),
    .rdata (fr_q)
  );

  mbb_ram #(.WIDTH(8), .DEPTH(SOURCE_BYTES)) u_source (
    .clk   (clk),
    .we    (src_we),
    .waddr (maddr[SBW-1:0]),
    .wdata (mem_data),
    .raddr (src_raddr),
    .rdata (src_q)
  );

  // Modify the fetched frame byte with the chosen pixel value
  logic src_ok;
  logic pix;
  logic [7:0] bmask;

  assign src_ok = (saddr < SAW'(SOURCE_BYTES));
  assign pix    = mode_blit ? (src_ok & src_q[3'd7 - sbit_sel]) : draw_val;
  assign bmask  = 8'd1 << fbit;

  assign busy      = (state != ST_IDLE);
  assign src_we    = (state == ST_IDLE) && start && (cmd == CMD_WRITE_SRC) &&
                     (maddr < MAW'(SOURCE_BYTES));
  assign src_raddr = saddr[SBW-1:0];
  assign fr_raddr  = (state == ST_READ) ? fidx : maddr[FAW-1:0];
  assign fr_we     = (state == ST_CLEAR) || (state == ST_WRITE);
  assign fr_waddr  = (state == ST_CLEAR) ? clr_cnt : fidx;
  assign fr_wdata  = (state == ST_CLEAR) ? 8'd0 : (pix ? (fr_q | bmask) : (fr_q & ~bmask));

  // Raise done in the cycle after a command finishes
  always_comb begin
    case (state)
      ST_IDLE:  done_next = start && !(is_draw && hit) && (cmd != CMD_CLEAR) &&
                            !((cmd == CMD_READ) && (maddr < MAW'(FRAME_BYTES)));
      ST_CLEAR: done_next = clr_reply && (clr_cnt == FAW'(FRAME_BYTES - 1));
      ST_WRITE: done_next = (i_cnt == cw - 1'b1) && (j_cnt == ch - 1'b1);
      ST_RDF:   done_next = 1'b1;
      default:  done_next = 1'b0;
    endcase
  end

  // Sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_CLEAR;
      clr_cnt   <= '0;
      clr_reply <= 1'b0;
      done      <= 1'b0;
      read_data <= 8'd0;
      drawn     <= 1'b0;
    end else begin
      done <= done_next;
      case (state)
        ST_IDLE: begin
          if (start) begin
            read_data <= 8'd0;
            drawn     <= is_draw && hit;
            case (cmd)
              CMD_BLIT, CMD_PIXEL, CMD_HLINE: begin
                cw        <= XW'(cx.cnt);
                ch        <= YW'(cy.cnt);
                cdx       <= cx.dst;
                cdy       <= cy.dst;
                csx       <= cx.src;
                csy       <= cy.src;
                mode_blit <= is_blit;
                draw_val  <= is_pix ? pixel_on : 1'b1;
                i_cnt     <= '0;
                j_cnt     <= '0;
                if (hit) begin
                  state <= ST_CALC;
                end
              end
              CMD_CLEAR: begin
                clr_cnt   <= '0;
                clr_reply <= 1'b1;
                state     <= ST_CLEAR;
              end
              CMD_READ: begin
                if (maddr < MAW'(FRAME_BYTES)) begin
                  state <= ST_RDF;
                end
              end
              default: ;
            endcase
          end
        end
        ST_CLEAR: begin
          clr_cnt <= clr_cnt + 1'b1;
          if (clr_cnt == FAW'(FRAME_BYTES - 1)) begin
            state     <= ST_IDLE;
            clr_reply <= 1'b0;
          end
        end
        ST_CALC: begin
          fidx     <= fidx_c[FAW-1:0];
          fbit     <= cur_y[2:0];
          saddr    <= saddr_c;
          sbit_sel <= scol[2:0];
          state    <= ST_READ;
        end
        ST_READ: begin
          state <= ST_WRITE;
        end
        ST_WRITE: begin
          // Advance across the row, then down
          if (i_cnt == cw - 1'b1) begin
            i_cnt <= '0;
            if (j_cnt == ch - 1'b1) begin
              state <= ST_IDLE;
            end else begin
              j_cnt <= j_cnt + 1'b1;
              state <= ST_CALC;
            end
          end else begin
            i_cnt <= i_cnt + 1'b1;
            state <= ST_CALC;
          end
        end
        ST_RDF: begin
          read_data <= fr_q;
          state     <= ST_IDLE;
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

endmodule
